// File: rtl/usbep0_pkg.sv
// ----------------------------------------------------------------------------
// usbep0_pkg
// Shared types and codes of the endpoint-zero control request handler.
// ----------------------------------------------------------------------------
package usbep0_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [6:0] MaxPacketReset = 7'd64;
  localparam logic [6:0] MaxPacketMin   = 7'd8;
  localparam logic [6:0] MaxPacketMax   = 7'd64;

  localparam logic [1:0] FUNC_SETUP    = 2'd0;
  localparam logic [1:0] FUNC_IN_DONE  = 2'd1;
  localparam logic [1:0] FUNC_OUT_DONE = 2'd2;
  localparam logic [1:0] FUNC_SUSPEND  = 2'd3;

  localparam logic [7:0] RT_STD_DEV_IN   = 8'h80;
  localparam logic [7:0] RT_STD_DEV_OUT  = 8'h00;
  localparam logic [7:0] RT_CLASS_IF_OUT = 8'h21;

  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

  localparam logic [7:0] DT_DEVICE = 8'd1;
  localparam logic [7:0] DT_STRING = 8'd3;

  typedef enum logic [2:0] {
    ACT_DATA  = 3'd0,
    ACT_ZLP   = 3'd1,
    ACT_RECV  = 3'd2,
    ACT_STALL = 3'd3,
    ACT_ADDR  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    OP_STALL   = 3'd0,
    OP_ZLP     = 3'd1,
    OP_ADDR    = 3'd2,
    OP_DESC    = 3'd3,
    OP_IN_DONE = 3'd4,
    OP_SUSPEND = 3'd5
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [1:0]  kind;
    logic [7:0]  index;
    logic [15:0] len;
    logic [6:0]  addr;
  } cmd_t;

  typedef struct packed {
    action_e     action;
    logic [1:0]  desc_kind;
    logic [7:0]  desc_index;
    logic [15:0] offset;
    logic [6:0]  size;
    logic [6:0]  address;
    logic        last;
  } res_t;

endpackage

// File: rtl/usb_ep0_control_request_handler_unit.sv
// ----------------------------------------------------------------------------
// usb_ep0_control_request_handler_unit
// Endpoint-zero control request handler with decoder, command queue and engine.
// ----------------------------------------------------------------------------
// Each event beat is decoded in the cycle it is taken and queued; the engine
// then drives one result beat per cycle while the output is not stalled,
// through a registered output; a set address or a final descriptor packet
// gives two results, other events at most one. Events that give no result are
// dropped at the decoder or taken by the engine without a result. The command
// queue holds QueueDepth events, so input beats keep flowing while the output
// is stalled until the queue fills. There is no clearing pass after reset.
module usb_ep0_control_request_handler_unit #(
  parameter int unsigned QueueDepth = usbep0_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_i,
  input  logic [7:0]  value_low_i,
  input  logic [7:0]  value_high_i,
  input  logic [15:0] setup_length_i,
  input  logic [15:0] desc_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [1:0]  desc_kind_o,
  output logic [7:0]  desc_index_o,
  output logic [15:0] offset_o,
  output logic [6:0]  size_o,
  output logic [6:0]  address_o,
  output logic        last_o
);
  import usbep0_pkg::*;

  logic [6:0] max_packet_q;
  logic [6:0] mp_clamped;
  logic       q_full, q_push, q_valid, q_pop;
  cmd_t       push_cmd, head_cmd;
  res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_packet_q <= MaxPacketReset;
    end else if (cfg_we_i) begin
      max_packet_q <= cfg_wdata_i;
    end
  end

  assign mp_clamped = (max_packet_q < MaxPacketMin) ? MaxPacketMin :
                      (max_packet_q > MaxPacketMax) ? MaxPacketMax : max_packet_q;

  usbep0_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .request_type_i (request_type_i),
    .request_i      (request_i),
    .value_low_i    (value_low_i),
    .value_high_i   (value_high_i),
    .setup_length_i (setup_length_i),
    .desc_length_i  (desc_length_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  usbep0_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  usbep0_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_packet_i (mp_clamped),
    .q_valid_i    (q_valid),
    .q_cmd_i      (head_cmd),
    .q_pop_o      (q_pop),
    .res_valid_o  (out_valid_o),
    .res_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign action_o     = res.action;
  assign desc_kind_o  = res.desc_kind;
  assign desc_index_o = res.desc_index;
  assign offset_o     = res.offset;
  assign size_o       = res.size;
  assign address_o    = res.address;
  assign last_o       = res.last;

endmodule

// File: rtl/usbep0_front.sv
// ----------------------------------------------------------------------------
// usbep0_front
// Event decoder: classifies each beat and queues the commands that it keeps.
// ----------------------------------------------------------------------------
module usbep0_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [7:0]          request_type_i,
  input  logic [7:0]          request_i,
  input  logic [7:0]          value_low_i,
  input  logic [7:0]          value_high_i,
  input  logic [15:0]         setup_length_i,
  input  logic [15:0]         desc_length_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output usbep0_pkg::cmd_t    q_cmd_o
);
  import usbep0_pkg::*;

  logic keep;
  cmd_t cmd;
  logic dt_ok;

  assign dt_ok = (value_high_i >= DT_DEVICE) && (value_high_i <= DT_STRING);

  always_comb begin
    keep      = 1'b0;
    cmd.op    = OP_STALL;
    cmd.kind  = value_high_i[1:0] - 2'd1;
    cmd.index = (value_high_i == DT_STRING) ? value_low_i : 8'd0;
    cmd.len   = (desc_length_i < setup_length_i) ? desc_length_i : setup_length_i;
    cmd.addr  = value_low_i[6:0];
    unique case (func_i)
      FUNC_SETUP: begin
        if (request_type_i == RT_STD_DEV_IN) begin
          if (request_i == REQ_GET_DESCRIPTOR) begin
            keep   = 1'b1;
            cmd.op = dt_ok ? OP_DESC : OP_STALL;
          end else if (request_i == REQ_GET_STATUS) begin
            keep   = 1'b1;
            cmd.op = OP_STALL;
          end
        end else if (request_type_i == RT_STD_DEV_OUT) begin
          if (request_i == REQ_SET_ADDRESS) begin
            keep   = 1'b1;
            cmd.op = OP_ADDR;
          end else if (request_i == REQ_SET_CONFIGURATION) begin
            keep   = 1'b1;
            cmd.op = OP_ZLP;
          end
        end else if (request_type_i == RT_CLASS_IF_OUT) begin
          keep   = 1'b1;
          cmd.op = OP_STALL;
        end
      end
      FUNC_IN_DONE: begin
        keep   = 1'b1;
        cmd.op = OP_IN_DONE;
      end
      FUNC_OUT_DONE: begin
        keep   = 1'b1;
        cmd.op = OP_ZLP;
      end
      FUNC_SUSPEND: begin
        keep   = 1'b1;
        cmd.op = OP_SUSPEND;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;
  assign q_cmd_o    = cmd;

endmodule

// File: rtl/usbep0_queue.sv
// ----------------------------------------------------------------------------
// usbep0_queue
// Short command queue between the decoder and the transfer engine.
// ----------------------------------------------------------------------------
module usbep0_queue #(
  parameter int unsigned Depth = usbep0_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  usbep0_pkg::cmd_t cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output usbep0_pkg::cmd_t cmd_o
);
  import usbep0_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count lost a push");
`endif

endmodule

// File: rtl/usbep0_back.sv
// ----------------------------------------------------------------------------
// usbep0_back
// Transfer engine: runs commands, splits descriptors into packets, drives results.
// ----------------------------------------------------------------------------
module usbep0_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [6:0]       max_packet_i,
  input  logic             q_valid_i,
  input  usbep0_pkg::cmd_t q_cmd_i,
  output logic             q_pop_o,
  output logic             res_valid_o,
  input  logic             res_stall_i,
  output usbep0_pkg::res_t res_o
);
  import usbep0_pkg::*;

  logic [15:0] remaining_q, remaining_d;
  logic [15:0] total_q, total_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  index_q, index_d;
  logic        pend_q, pend_d;
  action_e     pend_act_q, pend_act_d;
  logic        out_valid_q, out_valid_d;
  res_t        out_q, out_d;

  logic        out_free;
  logic        is_desc;
  logic [15:0] tot_use, rem_use, pkt_off, rem_sub;
  logic        big;
  logic [6:0]  pkt_size;
  logic [15:0] rem_next;
  res_t        data_res;

  assign out_free = !out_valid_q || !res_stall_i;
  assign q_pop_o  = out_free && !pend_q && q_valid_i;
  assign is_desc  = (q_cmd_i.op == OP_DESC);
  assign tot_use  = is_desc ? q_cmd_i.len : total_q;
  assign rem_use  = is_desc ? q_cmd_i.len : remaining_q;
  assign pkt_off  = tot_use - rem_use;
  assign big      = rem_use > {9'd0, max_packet_i};
  assign rem_sub  = rem_use - {9'd0, max_packet_i};
  assign pkt_size = big ? max_packet_i : rem_use[6:0];
  assign rem_next = big ? rem_sub : 16'd0;

  always_comb begin
    data_res            = '0;
    data_res.action     = ACT_DATA;
    data_res.desc_kind  = is_desc ? q_cmd_i.kind : kind_q;
    data_res.desc_index = is_desc ? q_cmd_i.index : index_q;
    data_res.offset     = pkt_off;
    data_res.size       = pkt_size;
    data_res.last       = (rem_next != 16'd0);
  end

  always_comb begin
    remaining_d = remaining_q;
    total_d     = total_q;
    kind_d      = kind_q;
    index_d     = index_q;
    pend_d      = pend_q;
    pend_act_d  = pend_act_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = 1'b0;
      if (pend_q) begin
        out_valid_d   = 1'b1;
        out_d         = '0;
        out_d.action  = pend_act_q;
        out_d.last    = 1'b1;
        pend_d        = 1'b0;
      end else if (q_valid_i) begin
        out_d      = '0;
        out_d.last = 1'b1;
        unique case (q_cmd_i.op)
          OP_STALL: begin
            out_valid_d  = 1'b1;
            out_d.action = ACT_STALL;
          end
          OP_ZLP: begin
            out_valid_d  = 1'b1;
            out_d.action = ACT_ZLP;
          end
          OP_ADDR: begin
            out_valid_d   = 1'b1;
            out_d.action  = ACT_ADDR;
            out_d.address = q_cmd_i.addr;
            out_d.last    = 1'b0;
            pend_d        = 1'b1;
            pend_act_d    = ACT_ZLP;
          end
          OP_SUSPEND: begin
            out_valid_d  = 1'b1;
            out_d.action = ACT_RECV;
            remaining_d  = 16'd0;
          end
          OP_DESC, OP_IN_DONE: begin
            if (is_desc == (remaining_q == 16'd0)) begin
              out_valid_d = 1'b1;
              out_d       = data_res;
              remaining_d = rem_next;
              total_d     = tot_use;
              kind_d      = data_res.desc_kind;
              index_d     = data_res.desc_index;
              if (rem_next == 16'd0) begin
                pend_d     = 1'b1;
                pend_act_d = ACT_RECV;
              end
            end
          end
          default: out_valid_d = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= 16'd0;
      total_q     <= 16'd0;
      kind_q      <= 2'd0;
      index_q     <= 8'd0;
      pend_q      <= 1'b0;
      pend_act_q  <= ACT_RECV;
      out_valid_q <= 1'b0;
    end else begin
      remaining_q <= remaining_d;
      total_q     <= total_d;
      kind_q      <= kind_d;
      index_q     <= index_d;
      pend_q      <= pend_d;
      pend_act_q  <= pend_act_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

`ifndef ASSERT_OFF
  a_pend_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q)
    else $error("second result pending without a first one shown");

  a_not_last_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> pend_q)
    else $error("non-final result without a follow-up");

  a_rem_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remaining_q <= total_q)
    else $error("remaining count exceeds transfer length");

  a_no_pop_while_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !q_pop_o)
    else $error("command taken while a result is still owed");
`endif

endmodule

// File: tb/sv/usb_ep0_control_request_handler_unit_tb.sv
// ----------------------------------------------------------------------------
// usb_ep0_control_request_handler_unit_tb
// Self-checking bench for the endpoint-zero control request handler.
// ----------------------------------------------------------------------------
// A table of directed events (reset state, request decode, stalls, address
// masking, empty and pending transfers) runs first. Constrained-by-hand random
// phases follow, mostly well-formed descriptor transfers with noise mixed in,
// each under another max packet setting and another mix of sender gaps and
// receiver stalls. Every accepted event beat goes through a behavioral
// predictor, and every result beat is compared field by field in order.
// ----------------------------------------------------------------------------
module usb_ep0_control_request_handler_unit_tb;
  import usbep0_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 8;

  localparam logic [1:0] KindDevice = 2'd0;
  localparam logic [1:0] KindString = 2'd2;
  localparam logic [7:0] DescTypeNone = 8'd0;
  localparam logic [7:0] DescTypeConfig = 8'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rt;
    logic [7:0]  rq;
    logic [7:0]  vl;
    logic [7:0]  vh;
    logic [15:0] wlen;
    logic [15:0] dlen;
  } ev_t;

  // nfix < 0: results come from the predictor; otherwise typed in
  typedef struct {
    ev_t  ev;
    int   nfix;
    res_t fix0;
    res_t fix1;
  } row_t;

  localparam res_t NoRes = '0;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [7:0]  request_type_i;
  logic [7:0]  request_i;
  logic [7:0]  value_low_i;
  logic [7:0]  value_high_i;
  logic [15:0] setup_length_i;
  logic [15:0] desc_length_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  action_o;
  logic [1:0]  desc_kind_o;
  logic [7:0]  desc_index_o;
  logic [15:0] offset_o;
  logic [6:0]  size_o;
  logic [6:0]  address_o;
  logic        last_o;

  int   beat_nfix;
  res_t beat_fix0;
  res_t beat_fix1;

  logic [6:0]  pkt_cfg = MaxPacketReset;
  logic [15:0] tx_left = '0;
  logic [15:0] tx_total = '0;
  logic [1:0]  held_kind = '0;
  logic [7:0]  held_index = '0;
  res_t        fresh [2];

  res_t        awaited_beats [$];
  row_t        plan [$];
  int unsigned live_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  usb_ep0_control_request_handler_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .request_type_i (request_type_i),
    .request_i      (request_i),
    .value_low_i    (value_low_i),
    .value_high_i   (value_high_i),
    .setup_length_i (setup_length_i),
    .desc_length_i  (desc_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .desc_kind_o    (desc_kind_o),
    .desc_index_o   (desc_index_o),
    .offset_o       (offset_o),
    .size_o         (size_o),
    .address_o      (address_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic res_t mkres(action_e act, logic [1:0] kind, logic [7:0] idx,
                                 logic [15:0] off, logic [6:0] sz, logic [6:0] addr,
                                 logic lst);
    res_t r;
    r.action     = act;
    r.desc_kind  = kind;
    r.desc_index = idx;
    r.offset     = off;
    r.size       = sz;
    r.address    = addr;
    r.last       = lst;
    return r;
  endfunction

  function automatic int unsigned pkt_limit();
    if (pkt_cfg < MaxPacketMin) return MaxPacketMin;
    if (pkt_cfg > MaxPacketMax) return MaxPacketMax;
    return pkt_cfg;
  endfunction

  function automatic int next_packet();
    int unsigned mp;
    logic [15:0] off;
    logic [6:0]  sz;
    mp  = pkt_limit();
    off = tx_total - tx_left;
    if (tx_left > mp) begin
      sz      = 7'(mp);
      tx_left = tx_left - 16'(mp);
    end else begin
      sz      = 7'(tx_left);
      tx_left = '0;
    end
    fresh[0] = mkres(ACT_DATA, held_kind, held_kind == KindString ? held_index : 8'd0,
                     off, sz, 7'd0, 1'b0);
    if (tx_left != 0) return 1;
    fresh[1] = mkres(ACT_RECV, '0, '0, '0, '0, '0, 1'b0);
    return 2;
  endfunction

  function automatic int forecast_event(input ev_t ev);
    int n;
    logic [15:0] len;
    n = 0;
    case (ev.func)
      FUNC_SETUP: begin
        if (ev.rt == RT_STD_DEV_IN) begin
          if (ev.rq == REQ_GET_DESCRIPTOR) begin
            if (ev.vh < DT_DEVICE || ev.vh > DT_STRING) begin
              fresh[0] = mkres(ACT_STALL, '0, '0, '0, '0, '0, 1'b0);
              n = 1;
            end else if (tx_left == 0) begin
              len        = (ev.dlen < ev.wlen) ? ev.dlen : ev.wlen;
              held_kind  = 2'(ev.vh - DT_DEVICE);
              held_index = (ev.vh == DT_STRING) ? ev.vl : 8'd0;
              tx_total   = len;
              tx_left    = len;
              n = next_packet();
            end
          end else if (ev.rq == REQ_GET_STATUS) begin
            fresh[0] = mkres(ACT_STALL, '0, '0, '0, '0, '0, 1'b0);
            n = 1;
          end
        end else if (ev.rt == RT_STD_DEV_OUT) begin
          if (ev.rq == REQ_SET_ADDRESS) begin
            fresh[0] = mkres(ACT_ADDR, '0, '0, '0, '0, ev.vl[6:0], 1'b0);
            fresh[1] = mkres(ACT_ZLP, '0, '0, '0, '0, '0, 1'b0);
            n = 2;
          end else if (ev.rq == REQ_SET_CONFIGURATION) begin
            fresh[0] = mkres(ACT_ZLP, '0, '0, '0, '0, '0, 1'b0);
            n = 1;
          end
        end else if (ev.rt == RT_CLASS_IF_OUT) begin
          fresh[0] = mkres(ACT_STALL, '0, '0, '0, '0, '0, 1'b0);
          n = 1;
        end
      end
      FUNC_IN_DONE: begin
        if (tx_left != 0) n = next_packet();
      end
      FUNC_OUT_DONE: begin
        fresh[0] = mkres(ACT_ZLP, '0, '0, '0, '0, '0, 1'b0);
        n = 1;
      end
      default: begin
        tx_left  = '0;
        fresh[0] = mkres(ACT_RECV, '0, '0, '0, '0, '0, 1'b0);
        n = 1;
      end
    endcase
    if (n > 0) fresh[n-1].last = 1'b1;
    return n;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    res_t e;
    ev_t  ev;
    int   n;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_beats.size() == 0) begin
          $error("result beat with nothing expected: action %0d", action_o);
          fail_cnt++;
        end else begin
          e = awaited_beats.pop_front();
          if (action_o !== e.action) begin
            $error("action: expected %0d, got %0d", e.action, action_o);
            fail_cnt++;
          end
          if (desc_kind_o !== e.desc_kind) begin
            $error("desc_kind: expected %0d, got %0d", e.desc_kind, desc_kind_o);
            fail_cnt++;
          end
          if (desc_index_o !== e.desc_index) begin
            $error("desc_index: expected %0d, got %0d", e.desc_index, desc_index_o);
            fail_cnt++;
          end
          if (offset_o !== e.offset) begin
            $error("offset: expected %0d, got %0d", e.offset, offset_o);
            fail_cnt++;
          end
          if (size_o !== e.size) begin
            $error("size: expected %0d, got %0d", e.size, size_o);
            fail_cnt++;
          end
          if (address_o !== e.address) begin
            $error("address: expected %0d, got %0d", e.address, address_o);
            fail_cnt++;
          end
          if (last_o !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last_o);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        ev.func = func_i;
        ev.rt   = request_type_i;
        ev.rq   = request_i;
        ev.vl   = value_low_i;
        ev.vh   = value_high_i;
        ev.wlen = setup_length_i;
        ev.dlen = desc_length_i;
        n = forecast_event(ev);
        if (n > 0) live_cnt++;
        if (beat_nfix < 0) begin
          for (int i = 0; i < n; i++) awaited_beats.push_back(fresh[i]);
        end else begin
          if (beat_nfix > 0) awaited_beats.push_back(beat_fix0);
          if (beat_nfix > 1) awaited_beats.push_back(beat_fix1);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic row_t drow(logic [1:0] f, logic [7:0] rt, logic [7:0] rq,
                                logic [7:0] vl, logic [7:0] vh, logic [15:0] wl,
                                logic [15:0] dl, int nfix, res_t a, res_t b);
    row_t r;
    r.ev   = '{f, rt, rq, vl, vh, wl, dl};
    r.nfix = nfix;
    r.fix0 = a;
    r.fix1 = b;
    return r;
  endfunction

  function automatic row_t as_row(input ev_t ev);
    row_t r;
    r.ev   = ev;
    r.nfix = -1;
    r.fix0 = NoRes;
    r.fix1 = NoRes;
    return r;
  endfunction

  function automatic ev_t noise_event();
    ev_t ev;
    ev.func = 2'($urandom_range(0, 3));
    ev.rt   = 8'($urandom);
    ev.rq   = 8'($urandom);
    ev.vl   = 8'($urandom);
    ev.vh   = 8'($urandom);
    ev.wlen = 16'($urandom);
    ev.dlen = 16'($urandom);
    return ev;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_event(input row_t r);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= r.ev.func;
    request_type_i <= r.ev.rt;
    request_i      <= r.ev.rq;
    value_low_i    <= r.ev.vl;
    value_high_i   <= r.ev.vh;
    setup_length_i <= r.ev.wlen;
    desc_length_i  <= r.ev.dlen;
    beat_nfix      <= r.nfix;
    beat_fix0      <= r.fix0;
    beat_fix1      <= r.fix1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited_beats.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic desc_transfer();
    ev_t ev;
    int unsigned len, more;
    bit cut;
    ev      = noise_event();
    ev.func = FUNC_SETUP;
    ev.rt   = RT_STD_DEV_IN;
    ev.rq   = REQ_GET_DESCRIPTOR;
    ev.vh   = 8'($urandom_range(DT_DEVICE, DT_STRING));
    if ($urandom_range(0, 7) != 0) begin
      ev.wlen = 16'($urandom_range(0, 300));
      ev.dlen = 16'($urandom_range(0, 300));
    end
    offer_event(as_row(ev));
    len  = (ev.wlen < ev.dlen) ? ev.wlen : ev.dlen;
    more = (len == 0) ? 0 : (len - 1) / pkt_limit();
    cut  = (more > 8);
    if (cut) begin
      more = $urandom_range(1, 8);
    end else begin
      case ($urandom_range(0, 9))
        0: more++;
        1: if (more > 0) more--;
        default: ;
      endcase
    end
    repeat (more) begin
      ev      = noise_event();
      ev.func = FUNC_IN_DONE;
      offer_event(as_row(ev));
    end
    ev      = noise_event();
    ev.func = (cut || $urandom_range(0, 6) == 0) ? FUNC_SUSPEND : FUNC_OUT_DONE;
    offer_event(as_row(ev));
  endtask

  task automatic run_phase(input logic [6:0] mp, input int unsigned gap,
                           input int unsigned stall, input int unsigned goal);
    int unsigned stop_at, pick;
    ev_t ev;
    drain(SettleCycles);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mp;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    pkt_cfg     = mp;
    gap_pct     = gap;
    stall_pct   = stall;
    stop_at     = live_cnt + goal;
    while (live_cnt < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        drain(0);
      end else if (pick < 55) begin
        desc_transfer();
      end else if (pick < 82) begin
        ev      = noise_event();
        ev.func = FUNC_SETUP;
        case ($urandom_range(0, 4))
          0: begin
            ev.rt = RT_STD_DEV_OUT;
            ev.rq = REQ_SET_ADDRESS;
          end
          1: begin
            ev.rt = RT_STD_DEV_OUT;
            ev.rq = REQ_SET_CONFIGURATION;
          end
          2: begin
            ev.rt = RT_STD_DEV_IN;
            ev.rq = REQ_GET_STATUS;
          end
          3: ev.rt = RT_CLASS_IF_OUT;
          default: begin
            ev.rt = RT_STD_DEV_IN;
            ev.rq = REQ_GET_DESCRIPTOR;
            ev.vh = $urandom_range(0, 1) ? DescTypeNone : 8'($urandom_range(4, 255));
          end
        endcase
        offer_event(as_row(ev));
      end else begin
        offer_event(as_row(noise_event()));
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    func_i         = '0;
    request_type_i = '0;
    request_i      = '0;
    value_low_i    = '0;
    value_high_i   = '0;
    setup_length_i = '0;
    desc_length_i  = '0;
    beat_nfix      = -1;
    beat_fix0      = NoRes;
    beat_fix1      = NoRes;

    plan.push_back(drow(FUNC_SUSPEND, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1,
                        mkres(ACT_RECV, '0, '0, '0, '0, '0, 1'b1), NoRes));
    plan.push_back(drow(FUNC_OUT_DONE, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1,
                        mkres(ACT_ZLP, '0, '0, '0, '0, '0, 1'b1), NoRes));
    plan.push_back(drow(FUNC_IN_DONE, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff, 0,
                        NoRes, NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_IN, REQ_GET_STATUS, 8'h00, 8'h00, 16'h0002,
                        16'h0000, 1, mkres(ACT_STALL, '0, '0, '0, '0, '0, 1'b1), NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_CLASS_IF_OUT, 8'hff, 8'hff, 8'hff, 16'hffff,
                        16'hffff, 1, mkres(ACT_STALL, '0, '0, '0, '0, '0, 1'b1), NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, 8'h00, DescTypeNone,
                        16'h0040, 16'h0012, 1, mkres(ACT_STALL, '0, '0, '0, '0, '0, 1'b1),
                        NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, 8'h00, 8'h04,
                        16'h0040, 16'h0012, 1, mkres(ACT_STALL, '0, '0, '0, '0, '0, 1'b1),
                        NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, 8'hff, 8'hff,
                        16'hffff, 16'hffff, 1, mkres(ACT_STALL, '0, '0, '0, '0, '0, 1'b1),
                        NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_OUT, REQ_SET_ADDRESS, 8'hff, 8'hff, 16'hffff,
                        16'hffff, 2, mkres(ACT_ADDR, '0, '0, '0, '0, 7'h7f, 1'b0),
                        mkres(ACT_ZLP, '0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_OUT, REQ_SET_ADDRESS, 8'h00, 8'h00, 16'h0000,
                        16'h0000, 2, mkres(ACT_ADDR, '0, '0, '0, '0, 7'h00, 1'b0),
                        mkres(ACT_ZLP, '0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_OUT, REQ_SET_CONFIGURATION, 8'h01, 8'h00,
                        16'h0000, 16'h0000, 1, mkres(ACT_ZLP, '0, '0, '0, '0, '0, 1'b1),
                        NoRes));
    plan.push_back(drow(FUNC_SETUP, 8'hff, REQ_GET_DESCRIPTOR, 8'h00, DT_DEVICE, 16'h0040,
                        16'h0012, 0, NoRes, NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_IN, 8'hff, 8'h00, DT_DEVICE, 16'h0040,
                        16'h0012, 0, NoRes, NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_OUT, REQ_GET_STATUS, 8'h00, 8'h00, 16'h0000,
                        16'h0000, 0, NoRes, NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, 8'h00, DT_DEVICE,
                        16'hffff, 16'd18, 2,
                        mkres(ACT_DATA, KindDevice, 8'd0, 16'd0, 7'd18, '0, 1'b0),
                        mkres(ACT_RECV, '0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, 8'hff, DT_STRING,
                        16'h0000, 16'hffff, 2,
                        mkres(ACT_DATA, KindString, 8'hff, 16'd0, 7'd0, '0, 1'b0),
                        mkres(ACT_RECV, '0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, 8'h07, DescTypeConfig,
                        16'hffff, 16'hffff, -1, NoRes, NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, 8'h00, DT_DEVICE,
                        16'd10, 16'd10, -1, NoRes, NoRes));
    plan.push_back(drow(FUNC_IN_DONE, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, -1,
                        NoRes, NoRes));
    plan.push_back(drow(FUNC_SUSPEND, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff, 1,
                        mkres(ACT_RECV, '0, '0, '0, '0, '0, 1'b1), NoRes));
    plan.push_back(drow(FUNC_IN_DONE, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 0,
                        NoRes, NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, 8'h05, DT_STRING,
                        16'd100, 16'd200, -1, NoRes, NoRes));
    plan.push_back(drow(FUNC_IN_DONE, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, -1,
                        NoRes, NoRes));
    plan.push_back(drow(FUNC_SETUP, RT_STD_DEV_IN, REQ_GET_DESCRIPTOR, 8'h00, DescTypeConfig,
                        16'd64, 16'd64, -1, NoRes, NoRes));
    plan.push_back(drow(FUNC_OUT_DONE, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff, -1,
                        NoRes, NoRes));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) offer_event(plan[i]);

    run_phase(MaxPacketMin, 0, 0, 70);
    run_phase(7'h7f, 59, 0, 70);
    run_phase(7'd0, 0, 59, 70);
    run_phase(MaxPacketMax, 35, 35, 70);
    run_phase(MaxPacketMin - 7'd1, 35, 35, 60);
    run_phase(MaxPacketMax + 7'd1, 59, 0, 60);
    run_phase(7'($urandom_range(9, 63)), 0, 59, 60);

    drain(SettleCycles);
    if (awaited_beats.size() != 0) begin
      $error("%0d result beats never arrived", awaited_beats.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
